// ===== rtl/core/set_duplicate_detector_core_macros.svh =====
// assertion macros used by the checker file
`ifndef SET_DUPLICATE_DETECTOR_CORE_MACROS_SVH
`define SET_DUPLICATE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, skipped while rst is high
`define SDD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdd check failed");

// next-cycle implication, skipped while rst is high
`define SDD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdd check failed");

`endif

// ===== rtl/core/sdd_pkg.sv =====
package sdd_pkg;

   // number of storage cells in the chain
   localparam int CAPACITY = 64;

   // width of one set element
   localparam int VALUE_W = 32;

   // result tdata is padded to a whole byte
   localparam int RSP_TDATA_W = 8;

   typedef logic signed [VALUE_W-1:0] value_type;

   // per-transaction control broadcast to every cell
   typedef struct packed {
      logic shift;
      logic clear;
      logic compare;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/set_duplicate_detector_core.sv =====
// Set duplicate detector.
// req channel: one set element per transaction in req_tdata (signed 32 bits),
// req_tlast marks the final element of a set. rsp channel: one transaction per
// set, rsp_tdata[0] = duplicate seen, rsp_tuser[0] = overflow (more than
// CAPACITY elements, answer may be incomplete).
// Elements sit in a chain of CAPACITY cells; a new element enters the first
// cell and pushes the others along, and every cell compares its entry with the
// incoming element in the same cycle. A full chain stops shifting.
// Throughput: one element per cycle while req_tready is high. For a last element,
// the result is registered in the cells, then ORed into the output register.
// The next set may follow in the cycle after a last element.
// Stall: a finished result waits in the output register; elements keep
// flowing until a second result is ready behind it, then req_tready drops
// until rsp_tready takes the first one.
// Reset (synchronous): empties the chain, drops any pending result and clears
// the flags; no clearing pass is needed.
module set_duplicate_detector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sdd_pkg::VALUE_W-1:0]         req_tdata,  // [31:0] value
   input  logic                                req_tlast,  // last
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sdd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [0] duplicate, rest zero
   output logic [0:0]                          rsp_tuser   // [0] overflow
);
   import sdd_pkg::*;

   value_type     chain_value [CAPACITY+1];
   logic          chain_valid [CAPACITY+1];
   logic [CAPACITY-1:0] match_vec;
   cell_ctrl_type ctrl;

   logic req_accept;
   logic chain_full;
   logic any_match;
   logic s1_hold;
   logic s1_advance;
   logic ovf_now;
   logic found_now;

   logic s1_valid_ff, s1_valid_in;
   logic s1_last_ff,  s1_last_in;
   logic s1_ovf_ff,   s1_ovf_in;
   logic ovf_flag_ff, ovf_flag_in;
   logic found_flag_ff, found_flag_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_dup_ff,   rsp_dup_in;
   logic rsp_ovf_ff,   rsp_ovf_in;

   // handshake
   assign s1_hold    = s1_valid_ff && s1_last_ff && rsp_valid_ff;
   assign req_tready = !s1_hold;
   assign req_accept = req_tvalid && req_tready;
   assign s1_advance = s1_valid_ff && !s1_hold;

   // chain control
   assign chain_full   = chain_valid[CAPACITY];
   assign ctrl.compare = req_accept;
   assign ctrl.clear   = req_accept && req_tlast;
   assign ctrl.shift   = req_accept && !req_tlast && !chain_full;

   // chain head is the incoming element
   assign chain_value[0] = value_type'(req_tdata);
   assign chain_valid[0] = 1'b1;

   // the cell chain
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      sdd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (chain_value[0]),
         .prev_value (chain_value[k]),
         .prev_valid (chain_valid[k]),
         .value      (chain_value[k+1]),
         .valid      (chain_valid[k+1]),
         .match      (match_vec[k])
      );
   end

   assign any_match = |match_vec;

   // overflow tracking at accept
   assign ovf_now = ovf_flag_ff || chain_full;

   always_comb begin
      ovf_flag_in = ovf_flag_ff;
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      s1_ovf_in   = s1_ovf_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req_tlast;
         s1_ovf_in   = ovf_now;
         ovf_flag_in = req_tlast ? 1'b0 : ovf_now;
      end
   end

   // second stage: fold cell matches into the set flag, emit on last
   assign found_now = found_flag_ff || any_match;

   always_comb begin
      found_flag_in = found_flag_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_dup_in    = rsp_dup_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         if (s1_last_ff) begin
            found_flag_in = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_dup_in    = found_now;
            rsp_ovf_in    = s1_ovf_ff;
         end else begin
            found_flag_in = found_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         ovf_flag_ff   <= 1'b0;
         found_flag_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         ovf_flag_ff   <= ovf_flag_in;
         found_flag_ff <= found_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
      s1_ovf_ff  <= s1_ovf_in;
      rsp_dup_ff <= rsp_dup_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // result ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_dup_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// ===== rtl/core/sdd_cell.sv =====
module sdd_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sdd_pkg::cell_ctrl_type ctrl,
   input  sdd_pkg::value_type    key,
   input  sdd_pkg::value_type    prev_value,
   input  logic                  prev_valid,
   output sdd_pkg::value_type    value,
   output logic                  valid,
   output logic                  match
);
   import sdd_pkg::*;

   value_type value_ff;
   value_type value_in;
   logic      valid_ff;
   logic      valid_in;
   logic      match_ff;
   logic      match_in;

   // take the neighbor's entry when the chain shifts, drop the entry on clear
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         value_in = prev_value;
         valid_in = prev_valid;
      end
   end

   // compare the broadcast key with the held entry, before any shift
   always_comb begin
      match_in = match_ff;
      if (ctrl.compare) begin
         match_in = valid_ff && (value_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

// ===== rtl/core/sdd_checker.sv =====
`include "set_duplicate_detector_core_macros.svh"

module sdd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sdd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser
);

   // no result is left over from before reset
   `SDD_ASSERT_NEXT(a_rsp_clear_after_reset, clock, 1'b0, reset, !rsp_tvalid)

   // input is only blocked while a result waits at the output
   `SDD_ASSERT_IMPL(a_block_needs_result, clock, reset, !req_tready, rsp_tvalid)

   // a blocked input frees up once the waiting result is taken
   `SDD_ASSERT_NEXT(a_unblock_after_take, clock, reset, !req_tready && rsp_tready, req_tready)

   // a stalled result holds its payload
   `SDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind set_duplicate_detector_core sdd_checker u_sdd_checker (.*);

// ===== sim/set_duplicate_detector_core_tb.sv =====
`timescale 1ns / 100ps

// expected outcome of one set
typedef struct {
   bit dup;
   bit ovf;
} set_verdict_type;

// tracks the elements of the current set and the verdicts still owed
class set_verdict_model;
   sdd_pkg::value_type held [sdd_pkg::CAPACITY];
   int unsigned        held_count;
   bit                 dup_seen;
   bit                 ovf_seen;
   set_verdict_type    expected_verdicts [$];
   int                 errors;
   int                 set_count;
   int                 dup_sets;
   int                 ovf_sets;

   // compare against every held element, then keep it if there is room
   function void note_element(sdd_pkg::value_type v, bit last);
      set_verdict_type verdict;
      for (int i = 0; i < held_count; i++) begin
         if (held[i] == v) dup_seen = 1'b1;
      end
      if (held_count < sdd_pkg::CAPACITY) begin
         held[held_count] = v;
         held_count++;
      end else begin
         ovf_seen = 1'b1;
      end
      if (last) begin
         verdict.dup = dup_seen;
         verdict.ovf = ovf_seen;
         expected_verdicts.push_back(verdict);
         set_count++;
         if (dup_seen) dup_sets++;
         if (ovf_seen) ovf_sets++;
         held_count = 0;
         dup_seen   = 1'b0;
         ovf_seen   = 1'b0;
      end
   endfunction

   // match one rsp transaction against the oldest owed verdict
   function void check_verdict(logic [sdd_pkg::RSP_TDATA_W-1:0] data, logic [0:0] user);
      set_verdict_type want;
      if (expected_verdicts.size() == 0) begin
         $display("%0t: unexpected result, tdata=%h tuser=%h", $time, data, user);
         errors++;
         return;
      end
      want = expected_verdicts.pop_front();
      if (data !== {{(sdd_pkg::RSP_TDATA_W-1){1'b0}}, want.dup}) begin
         $display("%0t: duplicate mismatch, expected tdata=%h actual tdata=%h", $time,
                  {{(sdd_pkg::RSP_TDATA_W-1){1'b0}}, want.dup}, data);
         errors++;
      end
      if (user !== want.ovf) begin
         $display("%0t: overflow mismatch, expected %0b actual %b", $time, want.ovf, user);
         errors++;
      end
   endfunction
endclass

module set_duplicate_detector_core_tb;

   localparam logic [31:0] VAL_MIN = 32'h8000_0000;
   localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sdd_pkg::VALUE_W-1:0]     req_tdata = '0;  // [31:0] value
   logic                            req_tlast = 1'b0;  // last
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sdd_pkg::RSP_TDATA_W-1:0] rsp_tdata;  // [0] duplicate, rest zero
   logic [0:0]                      rsp_tuser;  // [0] overflow

   set_verdict_model sets = new();
   bit               pace_gaps = 1'b1;
   int               items_sent = 0;

   set_duplicate_detector_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #2ms;
      $display("set_duplicate_detector_core test failed");
      $finish;
   end

   // push one element; called at a falling edge, returns at a falling edge
   task automatic send_element(input logic [31:0] v, input bit last);
      int gap;
      gap = pace_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sets.note_element(v, last);
      items_sent++;
      @(negedge clock);
   endtask

   // result side with random stalls
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pace_gaps ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sets.check_verdict(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int          set_size;
      int          dup_pct;
      int          drain;
      logic [31:0] v;
      logic [31:0] members [$];

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: one-element sets, extremes, equal pairs
      send_element(32'd5, 1'b1);
      send_element(VAL_MIN, 1'b0);
      send_element(VAL_MAX, 1'b1);
      send_element(32'd0, 1'b0);
      send_element(32'hffff_ffff, 1'b0);
      send_element(32'd0, 1'b1);
      send_element(VAL_MAX, 1'b0);
      send_element(32'd7, 1'b0);
      send_element(VAL_MAX, 1'b1);
      send_element(VAL_MIN, 1'b0);
      send_element(VAL_MIN, 1'b1);
      send_element(32'hffff_ffff, 1'b1);
      send_element(32'h5555_5555, 1'b0);
      send_element(32'haaaa_aaaa, 1'b0);
      send_element(32'h5555_5554, 1'b1);
      send_element(32'haaaa_aaaa, 1'b0);
      send_element(32'h5555_5555, 1'b0);
      send_element(32'haaaa_aaaa, 1'b1);

      // random sets, mostly short, some around and past capacity
      while (items_sent < 800) begin
         pace_gaps = ((sets.set_count / 12) % 3) != 0;
         if ($urandom_range(0, 19) == 0)
            set_size = $urandom_range(sdd_pkg::CAPACITY - 2, sdd_pkg::CAPACITY + 6);
         else
            set_size = $urandom_range(1, 10);
         dup_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
         members.delete();
         for (int k = 0; k < set_size; k++) begin
            if (members.size() != 0 && $urandom_range(0, 99) < dup_pct)
               v = members[$urandom_range(0, members.size() - 1)];
            else if ($urandom_range(0, 15) == 0)
               case ($urandom_range(0, 3))
                  0: v = VAL_MIN;
                  1: v = VAL_MAX;
                  2: v = 32'd0;
                  default: v = 32'hffff_ffff;
               endcase
            else
               v = $urandom;
            members.push_back(v);
            send_element(v, k == set_size - 1);
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // drain owed verdicts, then allow the pipeline to settle
      drain = 0;
      while (sets.expected_verdicts.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (sets.expected_verdicts.size() != 0) begin
         $display("%0t: %0d set verdicts never arrived", $time,
                  sets.expected_verdicts.size());
         sets.errors++;
      end

      $display("run covered %0d elements in %0d sets: %0d with a repeat, %0d past capacity",
               items_sent, sets.set_count, sets.dup_sets, sets.ovf_sets);
      if (sets.errors == 0)
         $display("set_duplicate_detector_core test passed");
      else
         $display("set_duplicate_detector_core test failed");
      $finish;
   end

endmodule
